// File: design/slfs_pkg.sv
// shared types and constants for the serpentine led frame store
// used by slfs_scale and serpentine_led_frame_store; no dependencies
package slfs_pkg;

    localparam int DEF_GRID_ROWS = 5;
    localparam int DEF_GRID_COLS = 5;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int BRIGHT_W = 7;
    localparam int INDEX_W = 6;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd100;

    // floor(p / 100) == (p * 5243) >> 19 for every p up to 255 * 127
    localparam int PROD_W      = CHAN_W + BRIGHT_W;
    localparam int RECIP_W     = 13;
    localparam int MUL_W       = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SHOW  = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_SHOW = 1'b1;

    typedef struct packed {
        logic              start;
        logic [CHAN_W-1:0] chan;
    } scl_req_t;

endpackage

// File: design/slfs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module slfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 25
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/slfs_scale.sv
// shared brightness scaling unit: floor(chan * bright / 100), saturated to 255
// one multiplier used twice per channel; depends on slfs_pkg
module slfs_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slfs_pkg::scl_req_t                req,
    input  logic [slfs_pkg::BRIGHT_W-1:0]     bright,
    output logic                              done,
    output logic [slfs_pkg::CHAN_W-1:0]       result
);
    import slfs_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DIV  = 2'd1;
    localparam logic [1:0] P_OUT  = 2'd2;

    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [MUL_W-1:0]   mul_reg;
    logic [MUL_W-1:0]   mul_next;
    logic [PROD_W-1:0]  op_a;
    logic [RECIP_W-1:0] op_b;
    logic [8:0]         quot;
    logic               load;

    assign load = req.start && ((phase_reg == P_IDLE) || (phase_reg == P_OUT));

    // first pass forms chan * bright, second pass multiplies by the reciprocal
    always_comb
    begin
        if (phase_reg == P_DIV)
        begin
            op_a = mul_reg[PROD_W-1:0];
            op_b = RECIP;
        end
        else
        begin
            op_a = PROD_W'(req.chan);
            op_b = RECIP_W'(bright);
        end
        mul_next = MUL_W'(op_a) * MUL_W'(op_b);
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            P_IDLE:  phase_next = load ? P_DIV : P_IDLE;
            P_DIV:   phase_next = P_OUT;
            P_OUT:   phase_next = load ? P_DIV : P_IDLE;
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load || (phase_reg == P_DIV))
        begin
            mul_reg <= mul_next;
        end
    end

    assign quot   = mul_reg[RECIP_SHIFT+8:RECIP_SHIFT];
    assign done   = (phase_reg == P_OUT);
    assign result = quot[8] ? {CHAN_W{1'b1}} : quot[CHAN_W-1:0];

endmodule

// File: design/serpentine_led_frame_store.sv
// Frame store for a serpentine-wired RGB LED grid with global brightness on show.
// A write is taken while idle and leaves busy low. An in-range read keeps busy high
// through the S_READ state after the transfer, and its result is registered from it.
// A show with nothing to emit leaves busy low; otherwise busy stays high while each
// LED steps through S_FETCH, S_LOAD, S_RED, S_GRN and S_BLU, paced by the registered
// frame-store read and the one shared scaling multiplier, which runs two passes for
// each of three channels. Results strobe on result_valid for one cycle each and
// cannot be stalled; the frame store reads as black until an LED is written.
// depends on slfs_pkg, slfs_ram and slfs_scale
module serpentine_led_frame_store #(
    parameter int GRID_ROWS = slfs_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = slfs_pkg::DEF_GRID_COLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       opcode,
    input  logic [2:0]                       row,
    input  logic [2:0]                       col,
    input  logic [slfs_pkg::COLOR_W-1:0]     color,
    input  logic                             force_req,
    input  logic                             bright_we,
    input  logic [slfs_pkg::BRIGHT_W-1:0]    bright_data,
    output logic                             result_valid,
    output logic                             result_kind,
    output logic [slfs_pkg::INDEX_W-1:0]     pixel_index,
    output logic [slfs_pkg::CHAN_W-1:0]      red,
    output logic [slfs_pkg::CHAN_W-1:0]      green,
    output logic [slfs_pkg::CHAN_W-1:0]      blue,
    output logic                             last
);
    import slfs_pkg::*;

    localparam int LED_COUNT = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(LED_COUNT - 1);
    localparam logic [6:0] COLS7 = 7'(GRID_COLS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_RED   = 3'd4;
    localparam logic [2:0] S_GRN   = 3'd5;
    localparam logic [2:0] S_BLU   = 3'd6;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [ADDR_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]    idx_next;
    logic [COLOR_W-1:0]   pix_reg;
    logic [COLOR_W-1:0]   pix_next;
    logic [CHAN_W-1:0]    red_reg;
    logic [CHAN_W-1:0]    red_next;
    logic [CHAN_W-1:0]    grn_reg;
    logic [CHAN_W-1:0]    grn_next;
    logic                 dirty_reg;
    logic                 dirty_next;
    logic [BRIGHT_W-1:0]  bright_reg;
    logic [LED_COUNT-1:0] valid_reg;
    logic [LED_COUNT-1:0] valid_next;

    logic                 strobe_reg;
    logic                 strobe_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 kind_reg;
    logic                 kind_next;
    logic [INDEX_W-1:0]   index_reg;
    logic [INDEX_W-1:0]   index_next;
    logic [CHAN_W-1:0]    ored_reg;
    logic [CHAN_W-1:0]    ored_next;
    logic [CHAN_W-1:0]    ogrn_reg;
    logic [CHAN_W-1:0]    ogrn_next;
    logic [CHAN_W-1:0]    oblu_reg;
    logic [CHAN_W-1:0]    oblu_next;

    logic                 accept;
    logic                 in_range;
    logic [6:0]           pos7;
    logic [ADDR_W-1:0]    pos_addr;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [COLOR_W-1:0]   ram_rd_data;
    logic [COLOR_W-1:0]   stored;
    scl_req_t             scl_req;
    logic                 scl_done;
    logic [CHAN_W-1:0]    scl_result;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // odd rows run right to left along the chain
    assign in_range = ({1'b0, row} < 4'(GRID_ROWS)) && ({1'b0, col} < 4'(GRID_COLS));
    always_comb
    begin
        if (row[0])
        begin
            pos7 = ({4'b0, row} + 7'd1) * COLS7 - {4'b0, col} - 7'd1;
        end
        else
        begin
            pos7 = {4'b0, row} * COLS7 + {4'b0, col};
        end
    end
    assign pos_addr = pos7[ADDR_W-1:0];

    assign ram_we      = accept && (opcode == OP_WRITE) && in_range;
    assign ram_rd_addr = (state_reg == S_IDLE) ? pos_addr : idx_reg;

    slfs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (LED_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (pos_addr),
        .wr_data (color),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // an LED never written reads as black
    assign stored = valid_reg[idx_reg] ? ram_rd_data : '0;

    slfs_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (scl_req),
        .bright (bright_reg),
        .done   (scl_done),
        .result (scl_result)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pix_next    = pix_reg;
        red_next    = red_reg;
        grn_next    = grn_reg;
        dirty_next  = dirty_reg;
        valid_next  = valid_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        kind_next   = kind_reg;
        index_next  = index_reg;
        ored_next   = ored_reg;
        ogrn_next   = ogrn_reg;
        oblu_next   = oblu_reg;
        scl_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_WRITE:
                        begin
                            if (in_range)
                            begin
                                valid_next[pos_addr] = 1'b1;
                                dirty_next           = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                idx_next   = pos_addr;
                                state_next = S_READ;
                            end
                        end
                        OP_SHOW:
                        begin
                            dirty_next = 1'b0;
                            if (force_req || dirty_reg)
                            begin
                                idx_next   = '0;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                kind_next   = KIND_READ;
                index_next  = INDEX_W'(idx_reg);
                ored_next   = stored[23:16];
                ogrn_next   = stored[15:8];
                oblu_next   = stored[7:0];
                state_next  = S_IDLE;
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                pix_next      = stored;
                scl_req.start = 1'b1;
                scl_req.chan  = stored[23:16];
                state_next    = S_RED;
            end
            S_RED:
            begin
                if (scl_done)
                begin
                    red_next      = scl_result;
                    scl_req.start = 1'b1;
                    scl_req.chan  = pix_reg[15:8];
                    state_next    = S_GRN;
                end
            end
            S_GRN:
            begin
                if (scl_done)
                begin
                    grn_next      = scl_result;
                    scl_req.start = 1'b1;
                    scl_req.chan  = pix_reg[7:0];
                    state_next    = S_BLU;
                end
            end
            S_BLU:
            begin
                if (scl_done)
                begin
                    strobe_next = 1'b1;
                    last_next   = (idx_reg == LAST_IDX);
                    kind_next   = KIND_SHOW;
                    index_next  = INDEX_W'(idx_reg);
                    ored_next   = red_reg;
                    ogrn_next   = grn_reg;
                    oblu_next   = scl_result;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = ADDR_W'(idx_reg + 1'b1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dirty_reg  <= 1'b0;
            bright_reg <= BRIGHT_RESET;
            valid_reg  <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dirty_reg  <= dirty_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            if (bright_we)
            begin
                bright_reg <= bright_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pix_reg   <= pix_next;
        red_reg   <= red_next;
        grn_reg   <= grn_next;
        kind_reg  <= kind_next;
        index_reg <= index_next;
        ored_reg  <= ored_next;
        ogrn_reg  <= ogrn_next;
        oblu_reg  <= oblu_next;
    end

    assign result_valid = strobe_reg;
    assign result_kind  = kind_reg;
    assign pixel_index  = index_reg;
    assign red          = ored_reg;
    assign green        = ogrn_reg;
    assign blue         = oblu_reg;
    assign last         = last_reg;

`ifndef ASSERT_OFF
    a_last_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid)
        else $error("last without a result transfer");

    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_READ)) |-> last)
        else $error("read result not marked last");

    a_show_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_SHOW)) |=> !dirty_reg)
        else $error("dirty flag survived a show");

    a_scale_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !scl_done)
        else $error("scaling unit finished while sequencer idle");

    a_emit_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("block still busy after final result");
`endif

endmodule

// File: verif/serpentine_led_frame_store_tb.sv
// self-checking testbench for serpentine_led_frame_store: writes, reads and shows
// over several brightness settings, results checked against a behavioral predictor
// depends on slfs_pkg and the serpentine_led_frame_store rtl
module serpentine_led_frame_store_tb;

    import slfs_pkg::*;

    localparam int ROWS          = DEF_GRID_ROWS;
    localparam int COLS          = DEF_GRID_COLS;
    localparam int LEDS          = ROWS * COLS;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 16;

    typedef struct {
        logic [1:0]         op;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [COLOR_W-1:0] color;
        logic               force_req;
        bit                 hold;      // wait for all pending results before issuing
    } frame_cmd_t;

    typedef struct {
        logic               kind;
        logic [INDEX_W-1:0] index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               last;
    } pixel_out_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          opcode = OP_WRITE;
    logic [2:0]          row = 3'd0;
    logic [2:0]          col = 3'd0;
    logic [COLOR_W-1:0]  color = '0;
    logic                force_req = 1'b0;
    logic                bright_we = 1'b0;
    logic [BRIGHT_W-1:0] bright_data = '0;
    logic                result_valid;
    logic                result_kind;
    logic [INDEX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic                last;

    frame_cmd_t          pending_cmds[$];
    pixel_out_t          expected_pixels[$];
    frame_cmd_t          cur_cmd;

    // predictor state
    logic [COLOR_W-1:0]  led_colors[LEDS];
    logic                frame_dirty = 1'b0;
    logic [BRIGHT_W-1:0] cur_brightness = BRIGHT_RESET;

    int                  mismatch_count = 0;
    int                  gap_left = 0;
    int                  stall_cycles = 0;

    serpentine_led_frame_store dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .row          (row),
        .col          (col),
        .color        (color),
        .force_req    (force_req),
        .bright_we    (bright_we),
        .bright_data  (bright_data),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .pixel_index  (pixel_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic logic [CHAN_W-1:0] scaled_chan(input logic [CHAN_W-1:0] chan);
        int v;
        v = int'(chan) * int'(cur_brightness) / 100;
        return (v > 255) ? 8'hff : CHAN_W'(v);
    endfunction

    task automatic predict_frame_op(input frame_cmd_t cmd);
        int         pos;
        pixel_out_t px;
        if (cmd.op == OP_WRITE || cmd.op == OP_READ)
        begin
            if (cmd.row >= ROWS || cmd.col >= COLS)
                return;
            // odd rows are wired right to left
            if (cmd.row[0])
                pos = (int'(cmd.row) + 1) * COLS - int'(cmd.col) - 1;
            else
                pos = int'(cmd.row) * COLS + int'(cmd.col);
            if (cmd.op == OP_WRITE)
            begin
                led_colors[pos] = cmd.color;
                frame_dirty = 1'b1;
            end
            else
            begin
                px.kind  = KIND_READ;
                px.index = INDEX_W'(pos);
                px.red   = led_colors[pos][23:16];
                px.green = led_colors[pos][15:8];
                px.blue  = led_colors[pos][7:0];
                px.last  = 1'b1;
                expected_pixels.push_back(px);
            end
        end
        else if (cmd.op == OP_SHOW)
        begin
            if (cmd.force_req || frame_dirty)
            begin
                for (int i = 0; i < LEDS; i++)
                begin
                    px.kind  = KIND_SHOW;
                    px.index = INDEX_W'(i);
                    px.red   = scaled_chan(led_colors[i][23:16]);
                    px.green = scaled_chan(led_colors[i][15:8]);
                    px.blue  = scaled_chan(led_colors[i][7:0]);
                    px.last  = (i == LEDS - 1);
                    expected_pixels.push_back(px);
                end
            end
            frame_dirty = 1'b0;
        end
    endtask

    task automatic push_cmd(input logic [1:0] op, input int r, input int c,
                            input logic [COLOR_W-1:0] rgb, input logic frc,
                            input bit hold);
        frame_cmd_t cmd;
        cmd.op        = op;
        cmd.row       = 3'(r);
        cmd.col       = 3'(c);
        cmd.color     = rgb;
        cmd.force_req = frc;
        cmd.hold      = hold;
        pending_cmds.push_back(cmd);
    endtask

    task automatic queue_random_cmds(input int count);
        int         sel;
        int         r;
        int         c;
        logic [1:0] op;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            r   = $urandom_range(0, ROWS - 1);
            c   = $urandom_range(0, COLS - 1);
            if (sel < 45)
                op = OP_WRITE;
            else if (sel < 70)
                op = OP_READ;
            else if (sel < 82)
                op = OP_SHOW;
            else
            begin
                // noise: unused opcode or an address off the grid
                sel = $urandom_range(0, 2);
                op  = (sel == 0) ? OP_WRITE : (sel == 1) ? OP_READ : OP_NONE;
                r   = $urandom_range(0, 7);
                c   = $urandom_range(0, 7);
                if (op != OP_NONE && r < ROWS && c < COLS)
                    c = $urandom_range(COLS, 7);
            end
            push_cmd(op, r, c, COLOR_W'($urandom), 1'($urandom),
                     ($urandom_range(0, 11) == 0));
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_brightness(input logic [BRIGHT_W-1:0] level);
        wait_drained();
        // writes and empty shows give no result, let them finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        bright_we   <= 1'b1;
        bright_data <= level;
        @(posedge clk);
        bright_we <= 1'b0;
        cur_brightness = level;
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_frame_op(cur_cmd);
                gap_left = $urandom_range(0, 5);
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].hold && expected_pixels.size() != 0))
                begin
                    cur_cmd = pending_cmds.pop_front();
                    start     <= 1'b1;
                    opcode    <= cur_cmd.op;
                    row       <= cur_cmd.row;
                    col       <= cur_cmd.col;
                    color     <= cur_cmd.color;
                    force_req <= cur_cmd.force_req;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && result_valid)
        begin
            if (expected_pixels.size() == 0)
            begin
                log_mismatch($sformatf("unexpected kind=%0d idx=%0d rgb=%h_%h_%h last=%0d",
                    result_kind, pixel_index, red, green, blue, last));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result_kind !== want.kind || pixel_index !== want.index ||
                    red !== want.red || green !== want.green || blue !== want.blue ||
                    last !== want.last)
                    log_mismatch({
                        $sformatf("exp kind=%0d idx=%0d rgb=%h_%h_%h last=%0d",
                            want.kind, want.index, want.red, want.green, want.blue,
                            want.last),
                        $sformatf(", got kind=%0d idx=%0d rgb=%h_%h_%h last=%0d",
                            result_kind, pixel_index, red, green, blue, last)});
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("serpentine_led_frame_store test failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [BRIGHT_W-1:0] levels[NUM_PHASES];
        for (int i = 0; i < LEDS; i++)
            led_colors[i] = '0;
        levels[0] = 7'd0;
        levels[1] = 7'd127;
        levels[2] = 7'd1;
        levels[3] = BRIGHT_W'($urandom_range(2, 126));
        levels[4] = 7'd100;
        levels[5] = BRIGHT_W'($urandom_range(0, 127));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset brightness
        push_cmd(OP_SHOW, 0, 0, 24'hffffff, 1'b0, 1'b0);   // clean frame, nothing shown
        push_cmd(OP_SHOW, 7, 7, 24'h000000, 1'b1, 1'b0);   // forced show of black frame
        push_cmd(OP_READ, 0, 0, 24'hffffff, 1'b1, 1'b1);   // unwritten led reads black
        push_cmd(OP_WRITE, 0, 0, 24'hffffff, 1'b0, 1'b0);
        push_cmd(OP_WRITE, 4, 4, 24'hffffff, 1'b1, 1'b0);
        push_cmd(OP_WRITE, 1, 0, 24'h123456, 1'b0, 1'b0);
        push_cmd(OP_WRITE, 1, 4, 24'ha5c33c, 1'b0, 1'b0);
        push_cmd(OP_WRITE, 4, 0, 24'h800001, 1'b0, 1'b0);
        push_cmd(OP_READ, 1, 0, 24'h000000, 1'b0, 1'b0);
        push_cmd(OP_READ, 1, 4, 24'h000000, 1'b0, 1'b0);
        push_cmd(OP_READ, 4, 4, 24'h000000, 1'b0, 1'b0);
        push_cmd(OP_READ, 0, 0, 24'h000000, 1'b0, 1'b0);
        push_cmd(OP_WRITE, 5, 0, 24'h00ff00, 1'b0, 1'b0);  // off-grid, ignored
        push_cmd(OP_WRITE, 7, 7, 24'hffffff, 1'b1, 1'b0);
        push_cmd(OP_READ, 0, 5, 24'h000000, 1'b0, 1'b0);
        push_cmd(OP_READ, 6, 3, 24'hffffff, 1'b1, 1'b0);
        push_cmd(OP_NONE, 0, 0, 24'hffffff, 1'b1, 1'b0);
        push_cmd(OP_SHOW, 0, 0, 24'h000000, 1'b0, 1'b0);   // dirty frame shown
        push_cmd(OP_SHOW, 0, 0, 24'h000000, 1'b0, 1'b0);   // clean again
        push_cmd(OP_WRITE, 3, 6, 24'h0000ff, 1'b0, 1'b0);  // off-grid write keeps it clean
        push_cmd(OP_SHOW, 3, 3, 24'h000000, 1'b0, 1'b0);
        push_cmd(OP_WRITE, 2, 2, 24'h0000ff, 1'b0, 1'b0);
        push_cmd(OP_SHOW, 2, 2, 24'h000000, 1'b0, 1'b0);
        push_cmd(OP_SHOW, 2, 2, 24'h000000, 1'b1, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_brightness(levels[p]);
            push_cmd(OP_WRITE, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                     24'hffffff, 1'b0, 1'b0);
            push_cmd(OP_SHOW, 0, 0, COLOR_W'($urandom), 1'b1, 1'b0);
            queue_random_cmds(PHASE_ITEMS);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
        if (mismatch_count == 0)
            $display("serpentine_led_frame_store test passed");
        else
            $display("serpentine_led_frame_store test failed");
        $finish;
    end

endmodule
